// File: design/lfe_pkg.sv
// Shared constants, register indexes and the sine table function for the light fade envelope.
`timescale 1ns / 1ps

package lfe_pkg;

    // Default generics
    localparam int SINE_TABLE_BITS_DEF = 8;
    localparam int TIME_BITS_DEF       = 16;

    // Fixed field widths
    localparam int Q16_W      = 17;          // Q0.16 value with room for 1.0
    localparam int DUR_W      = 16;
    localparam int DELTA_W    = 16;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int LANES      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [Q16_W-1:0] Q16_ONE = 17'h10000;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FADE_DURATION      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE_MODE         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_COLOR         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_FIRST_END    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_SECOND_START = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_SECOND_END   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_FINAL_START  = 3'd6;

    // Register reset values
    localparam logic [DUR_W-1:0] BLINK_FIRST_END_RST    = 16'd16384;
    localparam logic [DUR_W-1:0] BLINK_SECOND_START_RST = 16'd24576;
    localparam logic [DUR_W-1:0] BLINK_SECOND_END_RST   = 16'd40960;
    localparam logic [DUR_W-1:0] BLINK_FINAL_START_RST  = 16'd57344;

    // Curve codes
    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_SINE   = 2'd1;
    localparam logic [1:0] CURVE_DSINE  = 2'd2;
    localparam logic [1:0] CURVE_BLINK  = 2'd3;

    // Input function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin(pi/2 * k / 2^tbits) in Q0.16: Q30 Taylor series to degree 13, rounded, clamped.
    // Evaluated at elaboration only.
    function automatic logic [Q16_W-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (HALF_PI_Q30 * 64'(k)) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        v    = (sum + 64'd8192) >> 14;
        if (v > 64'd65536)
        begin
            v = 64'd65536;
        end
        return v[Q16_W-1:0];
    endfunction

endpackage

// File: design/lfe_sine_rom.sv
// Quarter-wave sine table with a registered read port.
`timescale 1ns / 1ps

module lfe_sine_rom #(
    parameter int TABLE_BITS = lfe_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic [TABLE_BITS:0]         addr,
    output logic [lfe_pkg::Q16_W-1:0]   data
);

    localparam int ENTRIES = (2 ** TABLE_BITS) + 1;
    localparam logic [TABLE_BITS:0] LAST_ADDR = {1'b1, {TABLE_BITS{1'b0}}};

    logic [lfe_pkg::Q16_W-1:0] rom [ENTRIES];
    logic [lfe_pkg::Q16_W-1:0] data_reg;

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_entry
        assign rom[k] = lfe_pkg::sine_entry(k, TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (addr > LAST_ADDR)
        begin
            data_reg <= rom[LAST_ADDR];
        end
        else
        begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule

// File: design/lfe_serial_div.sv
// Restoring divider, one quotient bit per cycle: (dividend << 16) / divisor, dividend <= divisor.
`timescale 1ns / 1ps

module lfe_serial_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lfe_pkg::DUR_W-1:0]   dividend,
    input  logic [lfe_pkg::DUR_W-1:0]   divisor,
    output logic                        done,
    output logic [lfe_pkg::Q16_W-1:0]   quotient
);

    localparam int QW    = lfe_pkg::Q16_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [QW-1:0]             rem_reg,  rem_next;
    logic [QW-1:0]             quot_reg, quot_next;
    logic [lfe_pkg::DUR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]          cnt_reg,  cnt_next;
    logic                      done_reg, done_next;

    logic          q_bit;
    logic [QW-1:0] rem_sub;

    always_comb
    begin
        q_bit     = (rem_reg >= QW'(dvs_reg));
        rem_sub   = q_bit ? (rem_reg - QW'(dvs_reg)) : rem_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = QW'(dividend);
            quot_next = '0;
            cnt_next  = CNT_W'(QW);
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so the shift cannot overflow
            rem_next  = {rem_sub[QW-2:0], 1'b0};
            quot_next = {quot_reg[QW-2:0], q_bit};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: design/light_fade_envelope_top.sv
// Top level of the light fade envelope: control sequencer, sine interpolation and colour scaling.
`timescale 1ns / 1ps

// Channel    | Dir | Handshake        | Payload
// -----------+-----+------------------+---------------------------------------------------
// s_axis     | in  | tvalid / tready  | tdata[15:0] delta_time, tuser[0] func
// m_axis     | out | tvalid / tready  | tdata: light_on, red, green, blue, updated, off
// cfg        | in  | cfg_we (no wait) | cfg_addr register index, cfg_wdata value
//
// One transfer in flight at a time. Start, inactive tick, zero duration and fade end go
// from IDLE straight to FINISH and the output register. A fading tick runs the divider (one
// quotient bit per cycle), then per sine pass (linear none, sine one, double sine and blink two)
// ROM reads, DIFF and serial interpolation multiply, then the 8-bit serial colour multiply.
// rst_n clears state and config asynchronously; the sine table is a constant ROM, no fill.
// A stalled m_axis holds the sequencer in its last step; s_tready stays low meanwhile.

module light_fade_envelope_top #(
    parameter int SINE_TABLE_BITS = lfe_pkg::SINE_TABLE_BITS_DEF,
    parameter int TIME_BITS       = lfe_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lfe_pkg::DELTA_W-1:0]      s_tdata,   // [15:0] delta_time
    input  logic                             s_tuser,   // [0] func
    // master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] light_on, [8:1] red_level, [16:9] green_level, [24:17] blue_level,
    // [25] color_updated, [26] switched_off, [31:27] zero
    output logic [lfe_pkg::OUT_DATA_W-1:0]   m_tdata,
    // configuration
    input  logic                             cfg_we,
    input  logic [lfe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lfe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int QW        = lfe_pkg::Q16_W;
    localparam int FRAC_BITS = 16 - SINE_TABLE_BITS;
    localparam int ADDR_W    = SINE_TABLE_BITS + 1;
    localparam int PROD_W    = QW + FRAC_BITS;
    localparam int CMP_W     = (TIME_BITS > lfe_pkg::DUR_W) ? TIME_BITS : lfe_pkg::DUR_W;
    localparam int SUM_W     = CMP_W + 1;
    localparam int CNT_MAX   = (FRAC_BITS > lfe_pkg::CHAN_W) ? FRAC_BITS : lfe_pkg::CHAN_W;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int ACC_W     = QW + lfe_pkg::CHAN_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
    localparam logic [ADDR_W-1:0]    LAST_ADDR = {1'b1, {SINE_TABLE_BITS{1'b0}}};

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DIV    = 8'b0000_0010,
        ST_RDA    = 8'b0000_0100,
        ST_RDB    = 8'b0000_1000,
        ST_DIFF   = 8'b0001_0000,
        ST_MUL    = 8'b0010_0000,
        ST_SCALE  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } fsm_state_t;

    // configuration registers
    logic [lfe_pkg::DUR_W-1:0]   dur_reg;
    logic [1:0]                  mode_reg;
    logic [lfe_pkg::COLOR_W-1:0] color_reg;
    logic [lfe_pkg::DUR_W-1:0]   th_first_end_reg;
    logic [lfe_pkg::DUR_W-1:0]   th_second_start_reg;
    logic [lfe_pkg::DUR_W-1:0]   th_second_end_reg;
    logic [lfe_pkg::DUR_W-1:0]   th_final_start_reg;

    // channel state
    fsm_state_t           state_reg, state_next;
    logic                 active_reg, active_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;

    // result flags for the item in progress
    logic res_on_reg,  res_on_next;
    logic res_upd_reg, res_upd_next;
    logic res_off_reg, res_off_next;

    // datapath
    logic [QW-1:0]             x_reg,     x_next;      // sine argument
    logic [QW-1:0]             a_reg,     a_next;      // lower table entry
    logic [QW-1:0]             diff_reg,  diff_next;
    logic [FRAC_BITS-1:0]      frac_reg,  frac_next;
    logic [PROD_W-1:0]         prod_reg,  prod_next;
    logic [QW-1:0]             f_reg,     f_next;      // final factor
    logic                      lit_reg,   lit_next;
    logic                      pass2_reg, pass2_next;  // second sine pass pending
    logic [CNT_W-1:0]          cnt_reg,   cnt_next;
    logic [lfe_pkg::COLOR_W-1:0] csh_reg, csh_next;    // colour bits, serial MSB first
    logic [ACC_W-1:0]          acc_reg  [lfe_pkg::LANES];
    logic [ACC_W-1:0]          acc_next [lfe_pkg::LANES];

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [lfe_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // divider and ROM hookup
    logic                       div_start;
    logic                       div_done;
    logic [QW-1:0]              div_quot;
    logic [ADDR_W-1:0]          rom_addr;
    logic [QW-1:0]              rom_data;

    logic                       s_xfer;
    logic [CMP_W-1:0]           elapsed_ext;
    logic [SUM_W-1:0]           elapsed_sum;
    logic [ADDR_W-1:0]          x_idx;
    logic [QW-1:0]              ratio_u;
    logic                       ratio_lit;
    logic [QW-1:0]              sine_val;

    lfe_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_ext[lfe_pkg::DUR_W-1:0]),
        .divisor  (dur_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    lfe_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg             <= '0;
            mode_reg            <= lfe_pkg::CURVE_LINEAR;
            color_reg           <= '0;
            th_first_end_reg    <= lfe_pkg::BLINK_FIRST_END_RST;
            th_second_start_reg <= lfe_pkg::BLINK_SECOND_START_RST;
            th_second_end_reg   <= lfe_pkg::BLINK_SECOND_END_RST;
            th_final_start_reg  <= lfe_pkg::BLINK_FINAL_START_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                lfe_pkg::REG_FADE_DURATION:      dur_reg   <= cfg_wdata[lfe_pkg::DUR_W-1:0];
                lfe_pkg::REG_CURVE_MODE:         mode_reg  <= cfg_wdata[1:0];
                lfe_pkg::REG_BASE_COLOR:         color_reg <= cfg_wdata;
                lfe_pkg::REG_BLINK_FIRST_END:
                    th_first_end_reg <= cfg_wdata[lfe_pkg::DUR_W-1:0];
                lfe_pkg::REG_BLINK_SECOND_START:
                    th_second_start_reg <= cfg_wdata[lfe_pkg::DUR_W-1:0];
                lfe_pkg::REG_BLINK_SECOND_END:
                    th_second_end_reg <= cfg_wdata[lfe_pkg::DUR_W-1:0];
                lfe_pkg::REG_BLINK_FINAL_START:
                    th_final_start_reg <= cfg_wdata[lfe_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign elapsed_ext = CMP_W'(elapsed_reg);
    // saturating advance of elapsed time
    assign elapsed_sum = SUM_W'(elapsed_reg) + SUM_W'(s_tdata);

    assign x_idx    = x_reg[QW-1:FRAC_BITS];
    assign ratio_u  = lfe_pkg::Q16_ONE - div_quot;
    assign ratio_lit = (div_quot < QW'(th_first_end_reg))
                    || ((div_quot >= QW'(th_second_start_reg))
                        && (div_quot < QW'(th_second_end_reg)))
                    || (div_quot >= QW'(th_final_start_reg));
    // interpolated sine once the serial product is complete
    assign sine_val = a_reg + QW'(prod_reg >> FRAC_BITS);

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        res_on_next  = res_on_reg;
        res_upd_next = res_upd_reg;
        res_off_next = res_off_reg;
        x_next       = x_reg;
        a_next       = a_reg;
        diff_next    = diff_reg;
        frac_next    = frac_reg;
        prod_next    = prod_reg;
        f_next       = f_reg;
        lit_next     = lit_reg;
        pass2_next   = pass2_reg;
        cnt_next     = cnt_reg;
        csh_next     = csh_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        rom_addr     = x_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    res_on_next  = 1'b0;
                    res_upd_next = 1'b0;
                    res_off_next = 1'b0;
                    for (int i = 0; i < lfe_pkg::LANES; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    state_next = ST_FINISH;
                    if (s_tuser == lfe_pkg::FUNC_START)
                    begin
                        elapsed_next = '0;
                        active_next  = 1'b1;
                        res_on_next  = 1'b1;
                    end
                    else if (active_reg)
                    begin
                        if (elapsed_sum > SUM_W'(TIME_MAX))
                        begin
                            elapsed_next = TIME_MAX;
                        end
                        else
                        begin
                            elapsed_next = elapsed_sum[TIME_BITS-1:0];
                        end
                        res_on_next = 1'b1;
                        if (dur_reg != '0)
                        begin
                            if (elapsed_ext > CMP_W'(dur_reg))
                            begin
                                active_next  = 1'b0;
                                res_on_next  = 1'b0;
                                res_off_next = 1'b1;
                            end
                            else
                            begin
                                res_upd_next = 1'b1;
                                div_start    = 1'b1;
                                state_next   = ST_DIV;
                            end
                        end
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    x_next     = ratio_u;
                    lit_next   = ratio_lit;
                    pass2_next = mode_reg[1];
                    if (mode_reg == lfe_pkg::CURVE_LINEAR)
                    begin
                        f_next     = ratio_u;
                        csh_next   = color_reg;
                        cnt_next   = CNT_W'(lfe_pkg::CHAN_W);
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        state_next = ST_RDA;
                    end
                end
            end

            ST_RDA:
            begin
                rom_addr   = x_idx;
                state_next = ST_RDB;
            end

            ST_RDB:
            begin
                // next entry; the end of the table has none beyond it
                rom_addr   = (x_idx >= LAST_ADDR) ? LAST_ADDR : (x_idx + 1'b1);
                a_next     = rom_data;
                state_next = ST_DIFF;
            end

            ST_DIFF:
            begin
                diff_next  = (rom_data < a_reg) ? '0 : (rom_data - a_reg);
                frac_next  = x_reg[FRAC_BITS-1:0];
                prod_next  = '0;
                cnt_next   = CNT_W'(FRAC_BITS);
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                if (cnt_reg != '0)
                begin
                    prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                              + (frac_reg[FRAC_BITS-1] ? PROD_W'(diff_reg) : '0);
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b0};
                    cnt_next  = cnt_reg - 1'b1;
                end
                else if (pass2_reg)
                begin
                    x_next     = sine_val;
                    pass2_next = 1'b0;
                    state_next = ST_RDA;
                end
                else
                begin
                    if ((mode_reg == lfe_pkg::CURVE_BLINK) && !lit_reg)
                    begin
                        f_next = '0;
                    end
                    else
                    begin
                        f_next = sine_val;
                    end
                    csh_next   = color_reg;
                    cnt_next   = CNT_W'(lfe_pkg::CHAN_W);
                    state_next = ST_SCALE;
                end
            end

            ST_SCALE:
            begin
                if (cnt_reg != '0)
                begin
                    for (int i = 0; i < lfe_pkg::LANES; i++)
                    begin
                        acc_next[i] = {acc_reg[i][ACC_W-2:0], 1'b0}
                            + (csh_reg[i*lfe_pkg::CHAN_W + lfe_pkg::CHAN_W - 1]
                               ? ACC_W'(f_reg) : '0);
                    end
                    for (int i = 0; i < lfe_pkg::LANES; i++)
                    begin
                        csh_next[i*lfe_pkg::CHAN_W +: lfe_pkg::CHAN_W] =
                            {csh_reg[i*lfe_pkg::CHAN_W +: lfe_pkg::CHAN_W - 1], 1'b0};
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, res_off_reg, res_upd_reg,
                                    acc_reg[0][ACC_W-2 -: lfe_pkg::CHAN_W],
                                    acc_reg[1][ACC_W-2 -: lfe_pkg::CHAN_W],
                                    acc_reg[2][ACC_W-2 -: lfe_pkg::CHAN_W],
                                    res_on_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            pass2_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            pass2_reg   <= pass2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_on_reg  <= res_on_next;
        res_upd_reg <= res_upd_next;
        res_off_reg <= res_off_next;
        x_reg       <= x_next;
        a_reg       <= a_next;
        diff_reg    <= diff_next;
        frac_reg    <= frac_next;
        prod_reg    <= prod_next;
        f_reg       <= f_next;
        lit_reg     <= lit_next;
        csh_reg     <= csh_next;
        acc_reg     <= acc_next;
        m_data_reg  <= m_data_next;
    end

endmodule

// File: dv/light_fade_envelope_top_tb.sv
// Self-checking testbench for light_fade_envelope_top: fade sequences checked against a predictor.
`timescale 1ns / 1ps

module light_fade_envelope_top_tb;

    import lfe_pkg::*;

    // Sine table geometry and run limits
    localparam int          SINE_BITS    = 8;
    localparam int          SINE_POINTS  = (1 << SINE_BITS) + 1;
    localparam int unsigned Q_ONE        = 65536;
    localparam logic [63:0] HALF_PI      = 64'd1686629713;   // pi/2 in Q30
    localparam int          FADE_ITEMS   = 1600;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          CYCLE_LIMIT  = 1000000;

    // Result layout on m_tdata, lowest bit last
    typedef struct packed {
        logic [4:0] pad;
        logic       switched_off;
        logic       color_updated;
        logic [7:0] blue_level;
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic       light_on;
    } fade_result_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    // Predictor of the fade envelope plus the queue of colours still owed by the block
    class fade_scoreboard;
        logic [15:0]  fade_len;
        logic [1:0]   curve;
        logic [23:0]  colour;
        logic [15:0]  first_end;
        logic [15:0]  second_start;
        logic [15:0]  second_end;
        logic [15:0]  final_start;
        logic         channel_on;
        logic [15:0]  time_acc;
        int unsigned  quarter_sine [SINE_POINTS];
        fade_result_t colour_q [$];
        int           errors;

        function new();
            fade_len     = '0;
            curve        = CURVE_LINEAR;
            colour       = '0;
            first_end    = BLINK_FIRST_END_RST;
            second_start = BLINK_SECOND_START_RST;
            second_end   = BLINK_SECOND_END_RST;
            final_start  = BLINK_FINAL_START_RST;
            channel_on   = 1'b0;
            time_acc     = '0;
            errors       = 0;
            for (int k = 0; k < SINE_POINTS; k++)
            begin
                quarter_sine[k] = sine_point(k);
            end
        endfunction

        // Q30 Taylor series to degree 13, rounded to Q0.16 and clamped at one
        function int unsigned sine_point(int unsigned k);
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] sum;
            logic [63:0] v;
            x    = (HALF_PI * 64'(k)) >> SINE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 11; n += 2)
            begin
                term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
                if (((n + 1) / 2) % 2 == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            v = (sum + 64'd8192) >> 14;
            if (v > 64'(Q_ONE))
            begin
                v = 64'(Q_ONE);
            end
            return 32'(v);
        endfunction

        // sin(pi/2 * x), linear interpolation between table points, product truncated
        function int unsigned sine_q16(int unsigned x);
            int unsigned idx;
            int unsigned frac;
            int unsigned lo;
            int unsigned hi;
            if (x >= Q_ONE)
            begin
                return quarter_sine[SINE_POINTS - 1];
            end
            idx  = x >> (16 - SINE_BITS);
            frac = x & ((1 << (16 - SINE_BITS)) - 1);
            lo   = quarter_sine[idx];
            hi   = quarter_sine[idx + 1];
            if (hi < lo)
            begin
                hi = lo;
            end
            return lo + (((hi - lo) * frac) >> (16 - SINE_BITS));
        endfunction

        function logic [7:0] level(logic [7:0] chan, int unsigned factor);
            return 8'((32'(chan) * factor) >> 16);
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FADE_DURATION:      fade_len     = val[15:0];
                REG_CURVE_MODE:         curve        = val[1:0];
                REG_BASE_COLOR:         colour       = val;
                REG_BLINK_FIRST_END:    first_end    = val[15:0];
                REG_BLINK_SECOND_START: second_start = val[15:0];
                REG_BLINK_SECOND_END:   second_end   = val[15:0];
                REG_BLINK_FINAL_START:  final_start  = val[15:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic func, logic [15:0] delta);
            fade_result_t res;
            int unsigned  ratio;
            int unsigned  factor;
            logic         lit;
            res = '0;
            if (func == FUNC_START)
            begin
                time_acc   = '0;
                channel_on = 1'b1;
            end
            else if (channel_on)
            begin
                if (fade_len != '0)
                begin
                    if (time_acc > fade_len)
                    begin
                        channel_on       = 1'b0;
                        res.switched_off = 1'b1;
                    end
                    else
                    begin
                        ratio = 32'((64'(time_acc) << 16) / 64'(fade_len));
                        if (ratio > Q_ONE)
                        begin
                            ratio = Q_ONE;
                        end
                        case (curve)
                            CURVE_LINEAR: factor = Q_ONE - ratio;
                            CURVE_SINE:   factor = sine_q16(Q_ONE - ratio);
                            default:      factor = sine_q16(sine_q16(Q_ONE - ratio));
                        endcase
                        if (curve == CURVE_BLINK)
                        begin
                            lit = ratio < first_end
                                  || (ratio >= second_start && ratio < second_end)
                                  || ratio >= final_start;
                            if (!lit)
                            begin
                                factor = 0;
                            end
                        end
                        res.red_level     = level(colour[23:16], factor);
                        res.green_level   = level(colour[15:8], factor);
                        res.blue_level    = level(colour[7:0], factor);
                        res.color_updated = 1'b1;
                    end
                end
                if (32'(time_acc) + 32'(delta) > 32'hFFFF)
                begin
                    time_acc = '1;
                end
                else
                begin
                    time_acc = time_acc + delta;
                end
            end
            res.light_on = channel_on;
            colour_q.push_back(res);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            fade_result_t got;
            fade_result_t want;
            got = data;
            if (colour_q.size() == 0)
            begin
                errors++;
                $error("result transfer %h with nothing outstanding", data);
                return;
            end
            want = colour_q.pop_front();
            check_field("light_on",      8'(want.light_on),      8'(got.light_on));
            check_field("red_level",     want.red_level,         got.red_level);
            check_field("green_level",   want.green_level,       got.green_level);
            check_field("blue_level",    want.blue_level,        got.blue_level);
            check_field("color_updated", 8'(want.color_updated), 8'(got.color_updated));
            check_field("switched_off",  8'(want.switched_off),  8'(got.switched_off));
            check_field("reserved",      8'(want.pad),           8'(got.pad));
        endfunction

        function int pending();
            return colour_q.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DELTA_W-1:0]    s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    fade_scoreboard sb = new();

    int       cycle_count  = 0;
    int       burst_left   = 0;
    rx_mode_t ready_mode   = RX_ALWAYS;
    int       ready_cycles = 0;

    light_fade_envelope_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("light_fade_envelope_top test failed");
            $finish;
        end
    end

    // Receiver back-pressure: a new stall pattern at random intervals
    always @(posedge clk)
    begin
        if (ready_cycles == 0)
        begin
            ready_mode   <= rx_mode_t'($urandom_range(0, 3));
            ready_cycles <= $urandom_range(50, 400);
        end
        else
        begin
            ready_cycles <= ready_cycles - 1;
        end
        case (ready_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_tready <= (cycle_count[2:0] < 3'd5);
        endcase
    end

    // Both monitors sample pre-edge values, so the driver's NBAs cannot race them
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sb.note_input(s_tuser, s_tdata);
        end
        if (m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
    end

    // One input transfer; returns at the edge that accepts it
    task automatic send_item(input logic func, input logic [15:0] delta);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= delta;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Sender gap; bus carries junk while tvalid is low
    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        s_tuser  <= 1'($urandom);
        s_tdata  <= 16'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Bursty sender: random runs of back-to-back transfers, the odd long unbroken run
    task automatic push_item(input logic func, input logic [15:0] delta);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                idle_sender(gap);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        send_item(func, delta);
    endtask

    // Hold the sender until every result is back, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Block must be idle; all seven registers rewritten back to back
    task automatic program_regs(input logic [15:0] dur, input logic [1:0] mode,
                                input logic [23:0] rgb, input logic [15:0] first_end,
                                input logic [15:0] second_start, input logic [15:0] second_end,
                                input logic [15:0] final_start);
        write_reg(REG_FADE_DURATION,      24'(dur));
        write_reg(REG_CURVE_MODE,         24'(mode));
        write_reg(REG_BASE_COLOR,         rgb);
        write_reg(REG_BLINK_FIRST_END,    24'(first_end));
        write_reg(REG_BLINK_SECOND_START, 24'(second_start));
        write_reg(REG_BLINK_SECOND_END,   24'(second_end));
        write_reg(REG_BLINK_FINAL_START,  24'(final_start));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_ratio();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Start, then a run of ticks sized so the fade usually runs out (or saturates)
    task automatic run_fade(input logic [15:0] dur, inout int fade_items);
        int          steps;
        int          span;
        logic [15:0] delta;
        steps = $urandom_range(2, 24);
        span  = (32'(dur) * 2) / steps + 1;
        push_item(FUNC_START, 16'($urandom));
        repeat (steps)
        begin
            case ($urandom_range(0, 9))
                0:       delta = 16'($urandom);
                1:       delta = '0;
                default: delta = 16'($urandom_range(0, span));
            endcase
            push_item(FUNC_TICK, delta);
        end
        fade_items += steps + 1;
    endtask

    task automatic run_phase(inout int fade_items);
        logic [15:0] dur;
        logic [1:0]  mode;
        logic [23:0] rgb;
        logic [15:0] thr [4];
        int          fades;
        case ($urandom_range(0, 9))
            0:       dur = 16'd0;
            1:       dur = 16'd1;
            2:       dur = 16'hFFFF;
            3:       dur = 16'($urandom_range(2, 16));
            4, 5:    dur = 16'($urandom_range(17, 400));
            6:       dur = 16'($urandom_range(401, 5000));
            default: dur = 16'($urandom);
        endcase
        mode = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0:       rgb = 24'h000000;
            1:       rgb = 24'hFFFFFF;
            default: rgb = 24'($urandom);
        endcase
        if ($urandom_range(0, 2) == 0)
        begin
            thr = '{BLINK_FIRST_END_RST, BLINK_SECOND_START_RST,
                    BLINK_SECOND_END_RST, BLINK_FINAL_START_RST};
        end
        else
        begin
            // any order goes: unordered thresholds just carve different intervals
            foreach (thr[i])
            begin
                thr[i] = pick_ratio();
            end
        end
        program_regs(dur, mode, rgb, thr[0], thr[1], thr[2], thr[3]);
        fades = $urandom_range(1, 6);
        repeat (fades)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // stray transfers: random function and delta
                repeat ($urandom_range(1, 4)) push_item(1'($urandom), 16'($urandom));
            end
            run_fade(dur, fade_items);
            if ($urandom_range(0, 7) == 0)
            begin
                wait_idle();
            end
        end
        wait_idle();
    endtask

    initial
    begin
        int fade_items;
        fade_items = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: tick while inactive, start, then hold with zero duration
        push_item(FUNC_TICK,  16'hFFFF);
        push_item(FUNC_START, 16'hFFFF);
        push_item(FUNC_TICK,  16'h1234);
        push_item(FUNC_TICK,  16'hFFFF);
        wait_idle();

        // Linear fade over 100: full colour, halfway, r = 1, switch-off, dead tick
        program_regs(16'd100, CURVE_LINEAR, 24'hFFFFFF, BLINK_FIRST_END_RST,
                     BLINK_SECOND_START_RST, BLINK_SECOND_END_RST, BLINK_FINAL_START_RST);
        push_item(FUNC_START, 16'd0);
        push_item(FUNC_TICK,  16'd0);
        push_item(FUNC_TICK,  16'd50);
        push_item(FUNC_TICK,  16'd50);
        push_item(FUNC_TICK,  16'd1);
        push_item(FUNC_TICK,  16'd0);
        push_item(FUNC_TICK,  16'd0);
        wait_idle();

        // Longest duration with sine curve: elapsed saturates, fade never ends
        program_regs(16'hFFFF, CURVE_SINE, 24'h80FF01, BLINK_FIRST_END_RST,
                     BLINK_SECOND_START_RST, BLINK_SECOND_END_RST, BLINK_FINAL_START_RST);
        push_item(FUNC_START, 16'd0);
        push_item(FUNC_TICK,  16'hFFFF);
        push_item(FUNC_TICK,  16'hFFFF);
        push_item(FUNC_TICK,  16'd0);
        wait_idle();

        // Double sine down to r = 1
        program_regs(16'd1000, CURVE_DSINE, 24'h00FF00, BLINK_FIRST_END_RST,
                     BLINK_SECOND_START_RST, BLINK_SECOND_END_RST, BLINK_FINAL_START_RST);
        push_item(FUNC_START, 16'd0);
        push_item(FUNC_TICK,  16'd500);
        push_item(FUNC_TICK,  16'd500);
        push_item(FUNC_TICK,  16'd1);
        wait_idle();

        // Blink: quarter steps land in lit, dark, lit, dark, lit
        program_regs(16'd4, CURVE_BLINK, 24'hFFFFFF, BLINK_FIRST_END_RST,
                     BLINK_SECOND_START_RST, BLINK_SECOND_END_RST, BLINK_FINAL_START_RST);
        push_item(FUNC_START, 16'd0);
        repeat (5) push_item(FUNC_TICK, 16'd1);
        wait_idle();

        while (fade_items < FADE_ITEMS)
        begin
            run_phase(fade_items);
        end

        // Anything left over or arriving late shows up here
        wait_idle();
        if (sb.pending() != 0)
        begin
            sb.errors++;
            $error("%0d results never arrived", sb.pending());
        end

        if (sb.errors == 0)
        begin
            $display("light_fade_envelope_top test passed");
        end
        else
        begin
            $display("light_fade_envelope_top test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/lfe_pkg.sv
design/lfe_sine_rom.sv
design/lfe_serial_div.sv
design/light_fade_envelope_top.sv
dv/light_fade_envelope_top_tb.sv
